@@ rtl/core/sbmq_pkg.sv @@
// Shared constants, types and helpers for the shared buffer multi queue.
package sbmq_pkg;

  localparam int DEPTH      = 16;
  localparam int QUEUES     = 4;
  localparam int DATA_WIDTH = 32;

  // Queue id width is fixed by the request format.
  localparam int QID_W  = 2;
  localparam int QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PTR_W  = $clog2(DEPTH + 1);

  // A pointer equal to DEPTH marks the end of a chain.
  localparam logic [PTR_W-1:0] NIL = PTR_W'(DEPTH);

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic accept;  // capture the request and launch the memory reads
    logic commit;  // apply the update and load the result register
  } cmd_t;

  function automatic logic is_slot(input logic [PTR_W-1:0] ptr);
    return ptr < NIL;
  endfunction

endpackage

@@ rtl/core/shared_buffer_multi_queue.sv @@
// Top level of the shared buffer multi queue: several FIFO queues in one linked buffer.
// A request word is captured together with its memory reads, and its commit then loads the
// result word, unless an earlier result word still waits there, which holds the commit back.
// A new request word is taken only once the previous one has committed, since the registered
// read of the link memory is followed by its write-back.
// Reset (rst, synchronous, active high) empties all queues and links every slot into the
// free list at once through per-slot valid bits; no clearing pass is needed.
module shared_buffer_multi_queue (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [sbmq_pkg::DATA_WIDTH-1:0]     s_tdata,   // [31:0] push_data
  input  logic [2:0]                          s_tuser,   // [0] req_type, [2:1] queue_id
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [sbmq_pkg::DATA_WIDTH-1:0]     m_tdata,   // [31:0] pop_data
  output logic [1:0]                          m_tuser    // [1:0] status
);

  // The controller sequences each request through a read cycle and a commit cycle.
  // A new request word is taken while a finished result word still waits on the
  // output side; only the commit waits for the result register to be free.
  sbmq_pkg::cmd_t cmd;

  sbmq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // The datapath holds the data buffer, the link memory, the queue head and tail
  // pointers, the free-list head and the result register.
  sbmq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req_type  (s_tuser[0]),
    .queue_id  (s_tuser[2:1]),
    .push_data (s_tdata),
    .pop_data  (m_tdata),
    .status    (m_tuser)
  );

endmodule

@@ rtl/core/sbmq_ctrl.sv @@
// Controller for the shared buffer multi queue: request sequencing and result handshake.
module sbmq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output sbmq_pkg::cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_valid;
  logic out_valid_next;

  always_comb begin
    cmd.accept = (state == S_IDLE) && s_tvalid;
    cmd.commit = (state == S_EXEC) && (!out_valid || m_tready);
    s_tready   = (state == S_IDLE);
    m_tvalid   = out_valid;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.commit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_commit_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("result register not loaded after commit");

  a_accept_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> !s_tready)
    else $error("input taken while a request is in flight");

  a_stall_holds_request: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && m_tvalid && !m_tready) |=> (state == S_EXEC))
    else $error("request left execution while result was stalled");

  a_commit_only_in_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !cmd.accept)
    else $error("commit and accept in the same cycle");
`endif

endmodule

@@ rtl/core/sbmq_dp.sv @@
// Datapath for the shared buffer multi queue: data and link memories, queue pointers, result.
module sbmq_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sbmq_pkg::cmd_t                        cmd,
  input  logic                                  req_type,
  input  logic [sbmq_pkg::QID_W-1:0]            queue_id,
  input  logic [sbmq_pkg::DATA_WIDTH-1:0]       push_data,
  output logic [sbmq_pkg::DATA_WIDTH-1:0]       pop_data,
  output logic [1:0]                            status
);

  localparam int PW = sbmq_pkg::PTR_W;
  localparam int AW = sbmq_pkg::ADDR_W;
  localparam int DW = sbmq_pkg::DATA_WIDTH;
  localparam int D  = sbmq_pkg::DEPTH;
  localparam int NQ = sbmq_pkg::QUEUES;
  localparam int QW = sbmq_pkg::QID_W;
  localparam int IW = sbmq_pkg::QIDX_W;

  logic [DW-1:0] data_mem [D];
  logic [PW-1:0] link_mem [D];
  logic [D-1:0]  link_wr;

  logic [PW-1:0] head [NQ];
  logic [PW-1:0] tail [NQ];
  logic [PW-1:0] free_head;

  logic          type_q;
  logic [QW-1:0] qid_q;
  logic [DW-1:0] word_q;
  logic [AW-1:0] rd_addr_q;
  logic [PW-1:0] link_q;
  logic          link_wr_q;
  logic [DW-1:0] data_q;

  logic          in_qid_ok;
  logic [PW-1:0] rd_ptr;
  logic [AW-1:0] rd_addr;

  logic          qid_ok;
  logic [IW-1:0] qidx;
  logic [PW-1:0] head_sel;
  logic [PW-1:0] tail_sel;
  logic [PW-1:0] link_val;
  logic          push_ok;
  logic          pop_ok;

  logic          lwr_en;
  logic [AW-1:0] lwr_addr;
  logic [PW-1:0] lwr_val;

  // Read address: the free-list head for a push, the queue head for a pop.
  always_comb begin
    in_qid_ok = (QW + 1)'(queue_id) < (QW + 1)'(NQ);
    if (req_type == sbmq_pkg::REQ_POP && in_qid_ok) begin
      rd_ptr = head[queue_id[IW-1:0]];
    end else begin
      rd_ptr = free_head;
    end
    rd_addr = rd_ptr[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      type_q    <= req_type;
      qid_q     <= queue_id;
      word_q    <= push_data;
      rd_addr_q <= rd_addr;
      link_q    <= link_mem[rd_addr];
      link_wr_q <= link_wr[rd_addr];
      data_q    <= data_mem[rd_addr];
    end
  end

  // An unwritten link entry holds its reset value: the next slot, or null for the last.
  always_comb begin
    qid_ok   = (QW + 1)'(qid_q) < (QW + 1)'(NQ);
    qidx     = qid_q[IW-1:0];
    head_sel = head[qidx];
    tail_sel = tail[qidx];
    link_val = link_wr_q ? link_q : (PW'(rd_addr_q) + PW'(1));
    push_ok  = qid_ok && sbmq_pkg::is_slot(free_head);
    pop_ok   = qid_ok && sbmq_pkg::is_slot(head_sel);
  end

  always_comb begin
    lwr_en   = 1'b0;
    lwr_addr = free_head[AW-1:0];
    lwr_val  = free_head;
    if (cmd.commit) begin
      if (type_q == sbmq_pkg::REQ_PUSH) begin
        if (push_ok && sbmq_pkg::is_slot(head_sel)) begin
          lwr_en   = 1'b1;
          lwr_addr = tail_sel[AW-1:0];
        end
      end else if (pop_ok) begin
        lwr_en   = 1'b1;
        lwr_addr = head_sel[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lwr_en) begin
      link_mem[lwr_addr] <= lwr_val;
    end
    if (cmd.commit && type_q == sbmq_pkg::REQ_PUSH && push_ok) begin
      data_mem[free_head[AW-1:0]] <= word_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_wr   <= '0;
      free_head <= '0;
      for (int i = 0; i < NQ; i++) begin
        head[i] <= sbmq_pkg::NIL;
        tail[i] <= sbmq_pkg::NIL;
      end
    end else begin
      if (lwr_en) begin
        link_wr[lwr_addr] <= 1'b1;
      end
      if (cmd.commit) begin
        if (type_q == sbmq_pkg::REQ_PUSH) begin
          if (push_ok) begin
            free_head <= link_val;
            tail[qidx] <= free_head;
            if (!sbmq_pkg::is_slot(head_sel)) begin
              head[qidx] <= free_head;
            end
          end
        end else if (pop_ok) begin
          free_head <= head_sel;
          if (head_sel == tail_sel) begin
            head[qidx] <= sbmq_pkg::NIL;
            tail[qidx] <= sbmq_pkg::NIL;
          end else begin
            head[qidx] <= link_val;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (type_q == sbmq_pkg::REQ_PUSH) begin
        pop_data <= '0;
        status   <= push_ok ? sbmq_pkg::ST_DONE : sbmq_pkg::ST_FULL;
      end else if (pop_ok) begin
        pop_data <= data_q;
        status   <= sbmq_pkg::ST_DONE;
      end else begin
        pop_data <= '1;
        status   <= sbmq_pkg::ST_EMPTY;
      end
    end
  end

endmodule

@@ test/tb_shared_buffer_multi_queue.sv @@
// Self-checking testbench for the shared buffer multi queue, with a predictor of its linked queues.
module tb_shared_buffer_multi_queue;

  localparam int DW           = sbmq_pkg::DATA_WIDTH;
  localparam int DEPTH        = sbmq_pkg::DEPTH;
  localparam int QUEUES       = sbmq_pkg::QUEUES;
  localparam int PTR_W        = sbmq_pkg::PTR_W;
  localparam int ADDR_W       = sbmq_pkg::ADDR_W;
  localparam int QID_W        = sbmq_pkg::QID_W;
  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off that backs the block up
  localparam int TAIL_CYCLES  = 10;    // settle time after the last result word
  localparam int LIMIT_CYCLES = 200000;

  typedef struct packed {
    logic [DW-1:0] pop_data;
    logic [1:0]    status;
  } result_t;

  // Tracks the slot chains of every queue and the free list, and holds the result words
  // still owed by the block in request order.
  class shared_queue_tracker;
    logic [DW-1:0]    word_at [DEPTH];
    logic [PTR_W-1:0] link_of [DEPTH];
    logic [PTR_W-1:0] head_of [QUEUES];
    logic [PTR_W-1:0] tail_of [QUEUES];
    logic [PTR_W-1:0] free_slot;
    result_t          due_results [$];
    int               errors;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        word_at[i] = '0;
        link_of[i] = PTR_W'(i + 1);
      end
      link_of[DEPTH-1] = sbmq_pkg::NIL;
      for (int q = 0; q < QUEUES; q++) begin
        head_of[q] = sbmq_pkg::NIL;
        tail_of[q] = sbmq_pkg::NIL;
      end
      free_slot = '0;
      errors    = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Applies one accepted request word and queues the result it must produce.
    function void note_request(logic kind, logic [QID_W-1:0] qid, logic [DW-1:0] word);
      result_t          r;
      logic [PTR_W-1:0] slot;
      int               q;
      q = int'(qid);
      if (kind == sbmq_pkg::REQ_PUSH) begin
        r.pop_data = '0;
        if (q >= QUEUES || free_slot >= sbmq_pkg::NIL) begin
          r.status = sbmq_pkg::ST_FULL;
        end else begin
          slot = free_slot;
          word_at[slot[ADDR_W-1:0]] = word;
          free_slot = link_of[slot[ADDR_W-1:0]];
          link_of[slot[ADDR_W-1:0]] = sbmq_pkg::NIL;
          if (head_of[q] >= sbmq_pkg::NIL) begin
            head_of[q] = slot;
          end else if (tail_of[q] < sbmq_pkg::NIL) begin
            link_of[tail_of[q][ADDR_W-1:0]] = slot;
          end
          tail_of[q] = slot;
          r.status = sbmq_pkg::ST_DONE;
        end
      end else if (q >= QUEUES || head_of[q] >= sbmq_pkg::NIL) begin
        r.pop_data = '1;
        r.status   = sbmq_pkg::ST_EMPTY;
      end else begin
        slot = head_of[q];
        head_of[q] = link_of[slot[ADDR_W-1:0]];
        link_of[slot[ADDR_W-1:0]] = free_slot;
        free_slot = slot;
        if (head_of[q] >= sbmq_pkg::NIL) begin
          tail_of[q] = sbmq_pkg::NIL;
        end
        r.pop_data = word_at[slot[ADDR_W-1:0]];
        r.status   = sbmq_pkg::ST_DONE;
      end
      due_results.push_back(r);
    endfunction

    // Compares one accepted result word with the oldest one owed.
    function void check_result(logic [DW-1:0] data, logic [1:0] status);
      result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: pop_data %h status %0d", $time, data, status);
        return;
      end
      want = due_results.pop_front();
      if (data !== want.pop_data) begin
        errors++;
        $display("%0t: pop_data mismatch: expected %h actual %h", $time, want.pop_data, data);
      end
      if (status !== want.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d actual %0d", $time, want.status, status);
      end
    endfunction
  endclass

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [DW-1:0]        s_tdata  = '0;
  logic [2:0]           s_tuser  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [DW-1:0]        m_tdata;
  logic [1:0]           m_tuser;

  shared_queue_tracker tracker = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;   // bumped by the stimulus to ask for a hold-off
  int hold_served    = 0;
  int hold_left      = 0;

  shared_buffer_multi_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #HALF_PERIOD clk = ~clk;

  // Offers one request word, idling first at the current rate, and holds it until taken.
  task automatic send_request(logic kind, logic [QID_W-1:0] qid, logic [DW-1:0] word);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= {qid, kind};
    do @(posedge clk); while (!s_tready);
    tracker.note_request(kind, qid, word);
  endtask

  task automatic pause_until_drained();
    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [DW-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return {1'b1, {(DW-1){1'b0}}};
      1:       return {1'b0, {(DW-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return DW'($urandom);
    endcase
  endfunction

  // Empty pops on every queue, a full buffer with extreme words, a refused push, then pops.
  task automatic run_directed();
    logic [DW-1:0] edge_words [6];
    edge_words[0] = {1'b1, {(DW-1){1'b0}}};
    edge_words[1] = {1'b0, {(DW-1){1'b1}}};
    edge_words[2] = '0;
    edge_words[3] = '1;
    edge_words[4] = {(DW/2){2'b01}};
    edge_words[5] = {(DW/2){2'b10}};
    for (int q = 0; q < QUEUES; q++) begin
      send_request(sbmq_pkg::REQ_POP, QID_W'(q), '1);
    end
    for (int i = 0; i < DEPTH; i++) begin
      send_request(sbmq_pkg::REQ_PUSH, QID_W'(i % QUEUES),
                   (i < 6) ? edge_words[i] : DW'($urandom));
    end
    send_request(sbmq_pkg::REQ_PUSH, QID_W'(2), edge_words[4]);
    for (int q = 0; q < QUEUES; q++) begin
      send_request(sbmq_pkg::REQ_POP, QID_W'(q), '0);
    end
  endtask

  // Random traffic in chunks that lean toward filling or draining, so that the buffer
  // is driven both full and empty; some chunks focus on a single queue.
  task automatic run_random(int count);
    int            push_pct;
    int            focus;
    logic          kind;
    logic [QID_W-1:0] qid;
    push_pct = 50;
    focus    = -1;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 15;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
        focus = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, QUEUES - 1)) : -1;
      end
      kind = ($urandom_range(0, 99) < push_pct) ? sbmq_pkg::REQ_PUSH : sbmq_pkg::REQ_POP;
      qid  = (focus >= 0) ? QID_W'(focus) : QID_W'($urandom_range(0, QUEUES - 1));
      send_request(kind, qid, pick_word());
    end
  endtask

  // Receiver: checks every accepted result word and sets the ready for the next cycle.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        tracker.check_result(m_tdata, m_tuser);
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    run_directed();

    // No idling; midway the receiver holds off while requests keep coming.
    run_random(190);
    hold_requests++;
    run_random(190);
    pause_until_drained();

    send_idle_pct  = 73;
    recv_stall_pct = 0;
    run_random(380);
    pause_until_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 73;
    run_random(380);
    pause_until_drained();

    send_idle_pct  = 21;
    recv_stall_pct = 21;
    run_random(385);
    pause_until_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/sbmq_pkg.sv
rtl/core/sbmq_ctrl.sv
rtl/core/sbmq_dp.sv
rtl/core/shared_buffer_multi_queue.sv
test/tb_shared_buffer_multi_queue.sv
